@@ src/lspg_pkg.sv @@
// Shared types, codes and tables for the LED strip pattern generator.
// No dependencies; used by lspg_div and led_strip_pattern_generator.
`timescale 1ns / 1ps
package lspg_pkg;

  localparam int STRIP_LEN_DEF = 64;
  localparam int AC_W          = 7;
  localparam int IDX_W         = 6;

  // mode codes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_IDLE    = 3'd1;
  localparam logic [2:0] MODE_READY   = 3'd2;
  localparam logic [2:0] MODE_FILLING = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MODE = 1'b1;

  // register addresses
  localparam logic [1:0] ADDR_ACTIVE_COUNT = 2'd0;

  // mode intervals in ms
  localparam logic [5:0] IVL_IDLE    = 6'd30;
  localparam logic [5:0] IVL_READY   = 6'd30;
  localparam logic [5:0] IVL_FILLING = 6'd50;
  localparam logic [5:0] IVL_DONE    = 6'd40;

  typedef struct packed {
    logic [0:0] operation;
    logic [2:0] new_mode;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [0:0] last_pixel;
  } out_item_t;

  // divider request and result
  typedef struct packed {
    logic        start;
    logic [14:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] quot;
    logic [6:0]  rem;
  } div_res_t;

  typedef logic [255:0][7:0] lut_t;

  // green level of the breathing animation for one step
  function automatic logic [7:0] ready_level(int unsigned step);
    logic [63:0] p;
    logic [63:0] quad;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] lvl;
    p    = ((64'(step) * 64'd65536) / 64'd255) & 64'hFFFF;
    quad = p >> 14;
    z    = p & 64'h3FFF;
    if (quad[0]) z = 64'd16384 - z;
    z2  = (z * z) >> 14;
    acc = 64'd1256749 - ((64'd43068 * z2) >> 14);
    acc = 64'd21392326 - ((acc * z2) >> 14);
    acc = 64'd173399667 - ((acc * z2) >> 14);
    acc = 64'd421657428 - ((acc * z2) >> 14);
    s   = (z * acc) >> 14;
    if (s > 64'd268435456) s = 64'd268435456;
    if (quad >= 64'd2) lvl = 64'd30 + ((64'd112 * (64'd268435456 - s)) >> 28);
    else lvl = 64'd30 + ((64'd112 * (64'd268435456 + s)) >> 28);
    return lvl[7:0];
  endfunction

  function automatic lut_t build_ready_lut();
    lut_t t;
    for (int k = 0; k < 256; k++) begin
      t[k] = ready_level(k);
    end
    return t;
  endfunction

  localparam lut_t READY_LUT = build_ready_lut();

  // floor(v/3) for v below 256
  function automatic logic [7:0] div3(logic [7:0] v);
    logic [16:0] m;
    m = 17'(v) * 17'd171;
    return m[16:9];
  endfunction

endpackage

@@ src/lspg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on lspg_pkg for the request and result structs.
`timescale 1ns / 1ps
module lspg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lspg_pkg::div_req_t req,
  output lspg_pkg::div_res_t res
);
  import lspg_pkg::*;

  logic [14:0] quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [6:0]  dsr_r, dsr_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  trial;
  logic [8:0]  diff;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem_r, quo_r[14]};
    diff     = {1'b0, trial} - {2'b00, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[8]) begin
        rem_nxt = diff[6:0];
        quo_nxt = {quo_r[13:0], 1'b1};
      end else begin
        rem_nxt = trial[6:0];
        quo_nxt = {quo_r[13:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd14) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

@@ src/led_strip_pattern_generator.sv @@
// Top level of the LED strip pattern generator: sequencer, state, pixel
// generation and APB register. Depends on lspg_pkg and lspg_div.
`timescale 1ns / 1ps
// Takes millisecond ticks and mode changes and produces whole frames of
// STRIP_LEN pixels, one pixel per transfer on the out_ channel. A mode change
// or a tick that emits nothing leaves in_stall low. In idle and filling
// modes the shared serial divider first works out the pixel spacing
// (360 / active_count) or the wrapped step; in the other modes the frame
// starts without it. in_stall stays high until the last pixel of a frame
// sits in the output register.
module led_strip_pattern_generator #(
  parameter int STRIP_LEN = lspg_pkg::STRIP_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lspg_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lspg_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lspg_pkg::*;

  localparam logic [1:0] S_WAIT = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [AC_W-1:0]  AC_MAX   = AC_W'(STRIP_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIP_LEN - 1);

  logic [1:0]      state_r, state_nxt;
  logic [2:0]      mode_r, mode_nxt;
  logic [8:0]      step_r, step_nxt;
  logic [5:0]      elapsed_r, elapsed_nxt;
  logic            refresh_r, refresh_nxt;
  logic [AC_W-1:0] ac_r, ac_nxt;
  logic [7:0]      lvl_r, lvl_nxt;
  logic [8:0]      qstep_r, qstep_nxt;
  logic [AC_W-1:0] rstep_r, rstep_nxt;
  logic [8:0]      qacc_r, qacc_nxt;
  logic [AC_W-1:0] racc_r, racc_nxt;
  logic [IDX_W-1:0] pix_r, pix_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  div_req_t div_req;
  div_res_t div_res;

  logic        in_acc, wr_en;
  logic [5:0]  el_inc, ivl;
  logic [8:0]  step_inc;
  logic [7:0]  done_step;
  logic [AC_W-1:0] wv;
  logic        load;
  logic        lit;
  logic [9:0]  pos_raw;
  logic [8:0]  pos;
  logic [6:0]  x;
  logic [10:0] t_mul;
  logic [7:0]  t;
  logic [7:0]  cr, cg, cb;
  logic [5:0]  d0, d;
  logic [7:0]  fb;
  logic [AC_W:0] rsum;
  out_item_t   pix_item;

  lspg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .res  (div_res)
  );

  assign in_stall  = (state_r != S_WAIT);
  assign in_acc    = in_valid && !in_stall;
  assign wr_en     = psel && penable && pwrite && (paddr == ADDR_ACTIVE_COUNT);
  assign pready    = 1'b1;
  assign prdata    = {{(32 - AC_W){1'b0}}, ac_r};
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // helpers for the tick path and the APB write value
  always_comb begin
    el_inc   = (elapsed_r < 6'd63) ? elapsed_r + 6'd1 : elapsed_r;
    step_inc = step_r + 9'd1;
    done_step = step_r[7:0] + 8'd1;
    case (mode_r)
      MODE_IDLE:    ivl = IVL_IDLE;
      MODE_READY:   ivl = IVL_READY;
      MODE_FILLING: ivl = IVL_FILLING;
      default:      ivl = IVL_DONE;
    endcase
    wv = pwdata[AC_W-1:0];
    if (wv < AC_W'(1)) wv = AC_W'(1);
    if (wv > AC_MAX) wv = AC_MAX;
  end

  // pixel color for the current index
  always_comb begin
    lit     = {1'b0, pix_r} < ac_r;
    pos_raw = {1'b0, step_r} + {1'b0, qacc_r};
    pos     = (pos_raw >= 10'd360) ? 9'(pos_raw - 10'd360) : pos_raw[8:0];
    if (pos < 9'd120) x = pos[6:0];
    else if (pos < 9'd240) x = 7'(pos - 9'd120);
    else x = 7'(pos - 9'd240);
    t_mul = 11'(x) * 11'd17;
    t     = t_mul[10:3];
    // distance from the running wave head
    d0 = (pix_r >= step_r[5:0]) ? pix_r - step_r[5:0] : step_r[5:0] - pix_r;
    d  = ({1'b0, d0} > (ac_r >> 1)) ? 6'(ac_r - AC_W'(d0)) : d0;
    fb = (d < 6'd4) ? 8'(8'd255 - 8'(d) * 8'd60) : 8'd15;
    cr = 8'd0;
    cg = 8'd0;
    cb = 8'd0;
    case (mode_r)
      MODE_IDLE: begin
        if (pos < 9'd120) begin
          cr = 8'd0; cg = 8'd255 - t; cb = t;
        end else if (pos < 9'd240) begin
          cr = t; cg = t; cb = 8'd255 - t;
        end else begin
          cr = 8'd255 - t; cg = 8'd255; cb = 8'd0;
        end
        cr = div3(cr);
        cg = div3(cg);
        cb = div3(cb);
      end
      MODE_READY, MODE_DONE: cg = lvl_r;
      MODE_FILLING: begin
        cg = {2'b00, fb[7:2]};
        cb = fb;
      end
      MODE_ERROR: cr = 8'd255;
      default: ;
    endcase
    pix_item.pixel_index = pix_r;
    pix_item.red         = lit ? cr : 8'd0;
    pix_item.green       = lit ? cg : 8'd0;
    pix_item.blue        = lit ? cb : 8'd0;
    pix_item.last_pixel  = (pix_r == LAST_IDX);
    rsum = {1'b0, racc_r} + {1'b0, rstep_r};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    step_nxt      = step_r;
    elapsed_nxt   = elapsed_r;
    refresh_nxt   = refresh_r;
    ac_nxt        = ac_r;
    lvl_nxt       = lvl_r;
    qstep_nxt     = qstep_r;
    rstep_nxt     = rstep_r;
    qacc_nxt      = qacc_r;
    racc_nxt      = racc_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = 15'd360;
    div_req.divisor  = ac_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (wr_en) begin
      ac_nxt      = wv;
      refresh_nxt = 1'b1;
    end

    case (state_r)
      S_WAIT: begin
        if (in_acc) begin
          if (in_data.operation == OP_MODE) begin
            if (in_data.new_mode <= MODE_ERROR && in_data.new_mode != mode_r) begin
              mode_nxt    = in_data.new_mode;
              step_nxt    = '0;
              elapsed_nxt = '0;
              refresh_nxt = 1'b1;
            end
          end else begin
            elapsed_nxt = el_inc;
            pix_nxt     = '0;
            qacc_nxt    = '0;
            racc_nxt    = '0;
            if (mode_r == MODE_OFF || mode_r == MODE_ERROR) begin
              if (refresh_r) begin
                refresh_nxt = 1'b0;
                state_nxt   = S_EMIT;
              end
            end else if (el_inc >= ivl) begin
              elapsed_nxt = '0;
              case (mode_r)
                MODE_IDLE: begin
                  step_nxt      = (step_r == 9'd359) ? 9'd0 : step_inc;
                  div_req.start = 1'b1;
                  state_nxt     = S_DIV;
                end
                MODE_READY: begin
                  step_nxt  = {1'b0, step_inc[7:0]};
                  lvl_nxt   = READY_LUT[step_inc[7:0]];
                  state_nxt = S_EMIT;
                end
                MODE_FILLING: begin
                  div_req.dividend = 15'(step_inc);
                  div_req.start    = 1'b1;
                  state_nxt        = S_DIV;
                end
                default: begin
                  if (step_r < 9'd80) begin
                    step_nxt  = {1'b0, done_step};
                    lvl_nxt   = (done_step < 8'd40) ? 8'd255
                              : 8'(8'd255 - (done_step - 8'd40) * 8'd6);
                    state_nxt = S_EMIT;
                  end
                end
              endcase
            end
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (mode_r == MODE_IDLE) begin
            qstep_nxt = div_res.quot[8:0];
            rstep_nxt = div_res.rem;
          end else begin
            step_nxt = {2'b00, div_res.rem};
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pix_item;
          pix_nxt       = pix_r + IDX_W'(1);
          // next pixel spacing offset
          if (rsum >= {1'b0, ac_r}) begin
            racc_nxt = AC_W'(rsum - {1'b0, ac_r});
            qacc_nxt = qacc_r + qstep_r + 9'd1;
          end else begin
            racc_nxt = rsum[AC_W-1:0];
            qacc_nxt = qacc_r + qstep_r;
          end
          if (pix_r == LAST_IDX) state_nxt = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      mode_r      <= MODE_IDLE;
      step_r      <= '0;
      elapsed_r   <= '0;
      refresh_r   <= 1'b1;
      ac_r        <= AC_MAX;
      out_valid_r <= 1'b0;
      pix_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      step_r      <= step_nxt;
      elapsed_r   <= elapsed_nxt;
      refresh_r   <= refresh_nxt;
      ac_r        <= ac_nxt;
      out_valid_r <= out_valid_nxt;
      pix_r       <= pix_nxt;
    end
    lvl_r      <= lvl_nxt;
    qstep_r    <= qstep_nxt;
    rstep_r    <= rstep_nxt;
    qacc_r     <= qacc_nxt;
    racc_r     <= racc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
